// ----- rtl/whp_pkg.sv -----
`default_nettype none

package whp_pkg;

	localparam int TIME_W   = 32;
	localparam int CNT_W    = 32;
	localparam int CIRC_W   = 12;
	localparam int SPEED_W  = 8;
	localparam int DEB_W    = 8;
	localparam int STUCK_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// wheel circumference * 3600 stays below 2^24
	localparam int NUM_W  = 24;
	localparam int STEP_W = $clog2(NUM_W);

	localparam int unsigned SPEED_MIN     = 20;
	localparam int unsigned SPEED_DEFAULT = 100;
	localparam int unsigned US_PER_MS     = 1000;
	// mm * 360000 / (km/h * 100) reduces to mm * 3600 / (km/h)
	localparam int unsigned PERIOD_FACTOR = 360000 / 100;

	localparam logic [CIRC_W-1:0]  CIRC_RESET  = CIRC_W'(2100);
	localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(80);
	localparam logic [DEB_W-1:0]   DEB_RESET   = DEB_W'(5);
	localparam logic [STUCK_W-1:0] STUCK_RESET = STUCK_W'(2000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CIRC  = 2'd0,
		CFG_SPEED = 2'd1,
		CFG_DEB   = 2'd2,
		CFG_STUCK = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REASON_NONE      = 2'd0,
		REASON_DEBOUNCE  = 2'd1,
		REASON_STUCK     = 2'd2,
		REASON_OVERSPEED = 2'd3
	} reason_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic [CIRC_W-1:0]  circ;
		logic [SPEED_W-1:0] speed;
		logic [DEB_W-1:0]   deb;
		logic [STUCK_W-1:0] stuck;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/wheel_pulse_qualifier.sv -----
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   pulse_time_us, released, active_time_us
// out       source     out_valid / out_stall accepted, reject_reason, first_accept,
//                                            elapsed_us, four event counters
// cfg       sink       cfg_we                cfg_index, cfg_data
//
// A pulse holds the input through the accepting cycle, the bit-serial divider steps for
// the minimum wheel period and the decision state. The result becomes valid at the edge
// that ends the decision state, and in_stall drops with it.
// Reset clears the history, counters and output valid, and loads the register
// defaults; no clearing pass is needed.
// A finished result sits in the output register while the next pulse is taken
// and divided; the decision waits only if that result is still stalled.

module wheel_pulse_qualifier
	import whp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// pulse transactions in
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [TIME_W-1:0]     pulse_time_us,
	input  wire logic                  released,
	input  wire logic [TIME_W-1:0]     active_time_us,
	// result transactions out
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       accepted,
	output logic [1:0]                 reject_reason,
	output logic                       first_accept,
	output logic [TIME_W-1:0]          elapsed_us,
	output logic [CNT_W-1:0]           accepted_count,
	output logic [CNT_W-1:0]           debounce_count,
	output logic [CNT_W-1:0]           stuck_count,
	output logic [CNT_W-1:0]           overspeed_count,
	// register writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	// register file: circumference, speed limit, debounce and stuck timeouts
	whp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: idle, divide, decide
	whp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// divider, qualification checks, history, counters and result register
	whp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.status          (status),
		.pulse_time_us   (pulse_time_us),
		.released        (released),
		.active_time_us  (active_time_us),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.reject_reason   (reject_reason),
		.first_accept    (first_accept),
		.elapsed_us      (elapsed_us),
		.accepted_count  (accepted_count),
		.debounce_count  (debounce_count),
		.stuck_count     (stuck_count),
		.overspeed_count (overspeed_count)
	);

endmodule

`default_nettype wire

// ----- rtl/whp_cfg.sv -----
`default_nettype none

module whp_cfg
	import whp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.circ  <= CIRC_RESET;
			cfg_q.speed <= SPEED_RESET;
			cfg_q.deb   <= DEB_RESET;
			cfg_q.stuck <= STUCK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CIRC:  cfg_q.circ  <= cfg_data[CIRC_W-1:0];
				CFG_SPEED: cfg_q.speed <= cfg_data[SPEED_W-1:0];
				CFG_DEB:   cfg_q.deb   <= cfg_data[DEB_W-1:0];
				CFG_STUCK: cfg_q.stuck <= cfg_data[STUCK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/whp_ctrl.sv -----
`default_nettype none

module whp_ctrl
	import whp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					step_d   = '0;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(NUM_W - 1)) begin
					state_d = ST_DECIDE;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			ST_DECIDE: begin
				// hold until the previous result has left the output register
				if (!status.out_busy) begin
					cmd.decide = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/whp_dp.sv -----
`default_nettype none

module whp_dp
	import whp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire cmd_t              cmd,
	output status_t                status,
	input  wire logic [TIME_W-1:0] pulse_time_us,
	input  wire logic              released,
	input  wire logic [TIME_W-1:0] active_time_us,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   accepted,
	output logic [1:0]             reject_reason,
	output logic                   first_accept,
	output logic [TIME_W-1:0]      elapsed_us,
	output logic [CNT_W-1:0]       accepted_count,
	output logic [CNT_W-1:0]       debounce_count,
	output logic [CNT_W-1:0]       stuck_count,
	output logic [CNT_W-1:0]       overspeed_count
);

	// captured transaction
	logic [TIME_W-1:0] t_q, act_q, deb_thr_q, stuck_thr_q;
	logic              rel_q;

	// restoring divider
	logic [NUM_W-1:0]   quo_q;
	logic [SPEED_W-1:0] rem_q, den_q;
	logic [SPEED_W:0]   trial;
	logic               ge;

	// persistent state
	logic [TIME_W-1:0] last_raw_q, last_acc_q;
	logic              raw_seen_q, acc_seen_q;
	logic [CNT_W-1:0]  acc_cnt_q, deb_cnt_q, stuck_cnt_q, over_cnt_q;

	// result register
	logic              out_valid_q, acc_out_q, first_q;
	reason_t           reason_q;
	logic [TIME_W-1:0] ivl_q;

	logic [SPEED_W-1:0] speed_eff;
	logic [TIME_W-1:0]  raw_gap, acc_gap;
	logic               is_deb, is_stuck, is_over;

	assign speed_eff = (cfg.speed < SPEED_W'(SPEED_MIN)) ? SPEED_W'(SPEED_DEFAULT) : cfg.speed;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	assign raw_gap  = t_q - last_raw_q;
	assign acc_gap  = t_q - last_acc_q;
	assign is_deb   = raw_seen_q && (raw_gap < deb_thr_q);
	assign is_stuck = acc_seen_q && !rel_q && (act_q >= stuck_thr_q);
	assign is_over  = (acc_gap == '0) || (acc_gap < TIME_W'(quo_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q         <= pulse_time_us;
			rel_q       <= released;
			act_q       <= active_time_us;
			deb_thr_q   <= TIME_W'(cfg.deb) * TIME_W'(US_PER_MS);
			stuck_thr_q <= TIME_W'(cfg.stuck) * TIME_W'(US_PER_MS);
			quo_q       <= NUM_W'(cfg.circ) * NUM_W'(PERIOD_FACTOR);
			rem_q       <= '0;
			den_q       <= speed_eff;
		end else if (cmd.div_step) begin
			rem_q <= ge ? SPEED_W'(trial - {1'b0, den_q}) : trial[SPEED_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= '0;
			last_acc_q  <= '0;
			raw_seen_q  <= 1'b0;
			acc_seen_q  <= 1'b0;
			acc_cnt_q   <= '0;
			deb_cnt_q   <= '0;
			stuck_cnt_q <= '0;
			over_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.decide) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.decide) begin
				// raw time follows every pulse, debounced or not
				last_raw_q <= t_q;
				raw_seen_q <= 1'b1;
				if (is_deb) begin
					deb_cnt_q <= deb_cnt_q + CNT_W'(1);
				end else if (is_stuck) begin
					stuck_cnt_q <= stuck_cnt_q + CNT_W'(1);
				end else if (acc_seen_q && is_over) begin
					over_cnt_q <= over_cnt_q + CNT_W'(1);
				end else begin
					last_acc_q <= t_q;
					acc_seen_q <= 1'b1;
					acc_cnt_q  <= acc_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			acc_out_q <= 1'b0;
			first_q   <= 1'b0;
			ivl_q     <= '0;
			if (is_deb) begin
				reason_q <= REASON_DEBOUNCE;
			end else if (is_stuck) begin
				reason_q <= REASON_STUCK;
			end else if (acc_seen_q && is_over) begin
				reason_q <= REASON_OVERSPEED;
			end else begin
				reason_q  <= REASON_NONE;
				acc_out_q <= 1'b1;
				first_q   <= !acc_seen_q;
				ivl_q     <= acc_seen_q ? acc_gap : '0;
			end
		end
	end

	assign status.out_busy = out_valid_q && out_stall;

	assign out_valid     = out_valid_q;
	assign accepted      = acc_out_q;
	assign reject_reason = reason_q;
	assign first_accept  = first_q;
	assign elapsed_us    = ivl_q;
	// counters only move on a decision, which waits for the output register to free up
	assign accepted_count  = acc_cnt_q;
	assign debounce_count  = deb_cnt_q;
	assign stuck_count     = stuck_cnt_q;
	assign overspeed_count = over_cnt_q;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none

module testbench
	import whp_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// Stretch with no transaction on any channel before the run is called hung.
	localparam int WATCHDOG_LIMIT = 2000;
	// Pipeline depth of one pulse plus margin, used before register writes and at the end
	localparam int SETTLE_CYCLES  = 40;
	localparam int ITEMS_PER_SET  = 210;
	localparam int RANDOM_SETS    = 8;
	localparam int MAX_REPORTS    = 10;

	// Scaling used by the qualifier
	localparam int unsigned LOW_SPEED      = 20;
	localparam int unsigned FALLBACK_SPEED = 100;
	localparam int unsigned MICROS_PER_MS  = 1000;
	localparam longint unsigned CIRC_SCALE  = 360000;
	localparam longint unsigned SPEED_SCALE = 100;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic              rel;
		logic [TIME_W-1:0] active;
	} pulse_t;

	typedef struct packed {
		logic              accepted;
		reason_t           reason;
		logic              first_accept;
		logic [TIME_W-1:0] interval;
		logic [CNT_W-1:0]  acc_cnt;
		logic [CNT_W-1:0]  deb_cnt;
		logic [CNT_W-1:0]  stuck_cnt;
		logic [CNT_W-1:0]  ovs_cnt;
	} verdict_t;

	// ---------------------------------------------------------------- DUT I/O
	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  in_valid       = 1'b0;
	logic                  in_stall;
	logic [TIME_W-1:0]     pulse_time_us  = '0;
	logic                  released       = 1'b0;
	logic [TIME_W-1:0]     active_time_us = '0;
	logic                  out_valid;
	logic                  out_stall      = 1'b0;
	logic                  accepted;
	logic [1:0]            reject_reason;
	logic                  first_accept;
	logic [TIME_W-1:0]     elapsed_us;
	logic [CNT_W-1:0]      accepted_count;
	logic [CNT_W-1:0]      debounce_count;
	logic [CNT_W-1:0]      stuck_count;
	logic [CNT_W-1:0]      overspeed_count;
	logic                  cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index      = CFG_CIRC;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;

	wheel_pulse_qualifier dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pulse_time_us   (pulse_time_us),
		.released        (released),
		.active_time_us  (active_time_us),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.reject_reason   (reject_reason),
		.first_accept    (first_accept),
		.elapsed_us      (elapsed_us),
		.accepted_count  (accepted_count),
		.debounce_count  (debounce_count),
		.stuck_count     (stuck_count),
		.overspeed_count (overspeed_count),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------- predictor state
	// register copies, reset values
	logic [CIRC_W-1:0]  reg_circ  = 12'd2100;
	logic [SPEED_W-1:0] reg_speed = 8'd80;
	logic [DEB_W-1:0]   reg_deb   = 8'd5;
	logic [STUCK_W-1:0] reg_stuck = 16'd2000;

	logic [TIME_W-1:0] last_raw   = '0;
	logic              raw_seen   = 1'b0;
	logic [TIME_W-1:0] last_acc   = '0;
	logic              acc_seen   = 1'b0;
	logic [CNT_W-1:0]  n_acc      = '0;
	logic [CNT_W-1:0]  n_deb      = '0;
	logic [CNT_W-1:0]  n_stuck    = '0;
	logic [CNT_W-1:0]  n_ovs      = '0;

	// -------------------------------------------------------- shared bookkeeping
	pulse_t   pulses_to_send[$];
	verdict_t expected_verdicts[$];
	logic     in_idle_on  = 1'b1;
	logic     out_idle_on = 1'b1;
	int       mismatches  = 0;
	int       verdicts_checked = 0;
	int       settings_used = 0;
	int       quiet_cycles = 0;
	logic [TIME_W-1:0] gen_time = '0;

	function automatic logic [TIME_W-1:0] debounce_window();
		return 32'(reg_deb) * 32'(MICROS_PER_MS);
	endfunction

	function automatic logic [TIME_W-1:0] stuck_window();
		return 32'(reg_stuck) * 32'(MICROS_PER_MS);
	endfunction

	// Shortest plausible wheel period in us; slow speed settings fall back
	function automatic logic [TIME_W-1:0] min_period();
		longint unsigned speed;
		speed = (reg_speed < LOW_SPEED) ? longint'(FALLBACK_SPEED) : longint'(reg_speed);
		return 32'((longint'(reg_circ) * CIRC_SCALE) / (speed * SPEED_SCALE));
	endfunction

	// Advances the predictor by one pulse and returns the verdict it must produce
	function automatic verdict_t qualify_pulse(pulse_t p);
		verdict_t v;
		logic [TIME_W-1:0] raw_gap;
		logic [TIME_W-1:0] acc_gap;
		v = '0;
		v.reason = REASON_NONE;
		raw_gap = p.stamp - last_raw;
		if (raw_seen && raw_gap < debounce_window()) begin
			n_deb++;
			v.reason = REASON_DEBOUNCE;
		end else begin
			raw_seen = 1'b1;
			// stuck only counts once something has been accepted
			if (acc_seen && !p.rel && p.active >= stuck_window()) begin
				n_stuck++;
				v.reason = REASON_STUCK;
			end else if (acc_seen) begin
				acc_gap = p.stamp - last_acc;
				if (acc_gap == '0 || acc_gap < min_period()) begin
					n_ovs++;
					v.reason = REASON_OVERSPEED;
				end else begin
					v.interval = acc_gap;
					v.accepted = 1'b1;
				end
			end else begin
				v.first_accept = 1'b1;
				v.accepted = 1'b1;
			end
			if (v.accepted) begin
				last_acc = p.stamp;
				acc_seen = 1'b1;
				n_acc++;
			end
		end
		// raw time moves on even for a debounced pulse
		last_raw = p.stamp;
		v.acc_cnt = n_acc;
		v.deb_cnt = n_deb;
		v.stuck_cnt = n_stuck;
		v.ovs_cnt = n_ovs;
		return v;
	endfunction

	// ------------------------------------------------------------------ driver
	int send_wait = 0;

	always @(posedge clk or negedge arst_n) begin
		pulse_t sent;
		pulse_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait = 0;
		end else begin
			// transaction taken at this edge: predict from what was on the pins
			if (in_valid && !in_stall) begin
				sent.stamp = pulse_time_us;
				sent.rel = released;
				sent.active = active_time_us;
				expected_verdicts.push_back(qualify_pulse(sent));
			end
			// a stalled payload stays put; otherwise idle or present the next pulse
			if (!(in_valid && in_stall)) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (pulses_to_send.size() != 0) begin
					nxt = pulses_to_send.pop_front();
					pulse_time_us <= nxt.stamp;
					released <= nxt.rel;
					active_time_us <= nxt.active;
					in_valid <= 1'b1;
					send_wait = in_idle_on ? int'($urandom_range(0, 15)) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ----------------------------------------------------------------- monitor
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.accepted = accepted;
				got.reason = reason_t'(reject_reason);
				got.first_accept = first_accept;
				got.interval = elapsed_us;
				got.acc_cnt = accepted_count;
				got.deb_cnt = debounce_count;
				got.stuck_cnt = stuck_count;
				got.ovs_cnt = overspeed_count;
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result transaction: acc=%0b reason=%0d",
							got.accepted, got.reason);
				end else begin
					want = expected_verdicts.pop_front();
					verdicts_checked++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("result %0d mismatch", verdicts_checked);
							$display("  exp acc=%0b rsn=%0d first=%0b ivl=%0d cnt=%0d/%0d/%0d/%0d",
								want.accepted, want.reason, want.first_accept, want.interval,
								want.acc_cnt, want.deb_cnt, want.stuck_cnt, want.ovs_cnt);
							$display("  got acc=%0b rsn=%0d first=%0b ivl=%0d cnt=%0d/%0d/%0d/%0d",
								got.accepted, got.reason, got.first_accept, got.interval,
								got.acc_cnt, got.deb_cnt, got.stuck_cnt, got.ovs_cnt);
						end
					end
				end
				hold_left = out_idle_on ? int'($urandom_range(0, 15)) : 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------- stimulus
	// Register write; the predictor copy masks to the register width as the block does
	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CIRC: begin
				reg_circ = val[CIRC_W-1:0];
			end
			CFG_SPEED: begin
				reg_speed = val[SPEED_W-1:0];
			end
			CFG_DEB: begin
				reg_deb = val[DEB_W-1:0];
			end
			CFG_STUCK: begin
				reg_stuck = val[STUCK_W-1:0];
			end
		endcase
	endtask

	task automatic load_settings(logic [15:0] circ, logic [15:0] speed,
		logic [15:0] deb, logic [15:0] stuck);
		write_reg(CFG_CIRC, circ);
		write_reg(CFG_SPEED, speed);
		write_reg(CFG_DEB, deb);
		write_reg(CFG_STUCK, stuck);
		settings_used++;
	endtask

	task automatic add_pulse(logic [TIME_W-1:0] stamp, logic rel, logic [TIME_W-1:0] active);
		pulse_t p;
		p.stamp = stamp;
		p.rel = rel;
		p.active = active;
		pulses_to_send.push_back(p);
	endtask

	// Block is idle once every pulse has gone in and every verdict come out
	task automatic wait_until_idle();
		while (pulses_to_send.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Mostly plausible wheel traffic following a running timestamp, with
	// debounce bursts, near-misses on every threshold, stuck sensors and noise.
	task automatic queue_random(int n);
		pulse_t p;
		int unsigned kind;
		int unsigned deb_w;
		int unsigned min_p;
		int unsigned stuck_w;
		int unsigned base;
		for (int i = 0; i < n; i++) begin
			deb_w = debounce_window();
			min_p = min_period();
			stuck_w = stuck_window();
			base = (deb_w > min_p) ? deb_w : min_p;
			kind = $urandom_range(0, 99);
			p.rel = 1'b1;
			p.active = $urandom;
			// a held but not yet stuck sensor now and then
			if (stuck_w > 0 && $urandom_range(0, 2) == 0) begin
				p.rel = 1'b0;
				p.active = $urandom_range(0, stuck_w - 1);
			end
			if (kind < 45) begin
				gen_time += base + $urandom_range(0, base + 1000);
			end else if (kind < 57) begin
				if (deb_w > 0)
					gen_time += $urandom_range(0, deb_w - 1);
			end else if (kind < 69) begin
				if (min_p > deb_w)
					gen_time += $urandom_range(deb_w, min_p - 1);
				else
					gen_time += base;
			end else if (kind < 79) begin
				gen_time += base + $urandom_range(0, 1000);
				p.rel = 1'b0;
				p.active = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF :
					stuck_w + $urandom_range(0, 5000000);
			end else if (kind < 89) begin
				// one short of / exactly on a threshold
				case ($urandom_range(0, 3))
					0: gen_time += deb_w;
					1: gen_time += deb_w - 1;
					2: gen_time += base;
					default: gen_time += base - 1;
				endcase
				if ($urandom_range(0, 1) == 1) begin
					p.rel = 1'b0;
					p.active = stuck_w - $urandom_range(0, 1);
				end
			end else if (kind < 92) begin
				// same timestamp again
				gen_time += 0;
			end else begin
				gen_time = $urandom;
				p.rel = 1'($urandom_range(0, 1));
				p.active = $urandom;
			end
			p.stamp = gen_time;
			pulses_to_send.push_back(p);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pass on the reset settings: 5 ms debounce, 94500 us period,
		// 2 s stuck timeout
		add_pulse(32'd100, 1'b0, 32'hFFFF_FFFF);     // first pulse, stuck check not armed
		add_pulse(32'd5099, 1'b1, 32'd0);            // debounce, one us short
		add_pulse(32'd10099, 1'b1, 32'd1234);        // clears debounce exactly, overspeed
		add_pulse(32'd94599, 1'b1, 32'd0);           // one us short of the period
		add_pulse(32'd200000, 1'b1, 32'hFFFF_FFFF);  // accepted, released ignores active time
		add_pulse(32'd294500, 1'b1, 32'd5);          // exactly one period
		add_pulse(32'd483500, 1'b0, 32'd2000000);    // stuck, on the timeout
		add_pulse(32'd493500, 1'b0, 32'd1999999);    // just under the timeout
		add_pulse(32'd493500, 1'b1, 32'd0);          // repeated stamp, debounced
		add_pulse(32'd593500, 1'b1, 32'hFFFF_FFFF);
		add_pulse(32'hFFFF_FFF0, 1'b0, 32'd0);
		add_pulse(32'd99984, 1'b1, 32'h5A5A_A5A5);   // interval across the wrap
		add_pulse(32'hFFFF_F000, 1'b1, 32'd0);
		add_pulse(32'h0000_0100, 1'b1, 32'd0);       // debounce across the wrap
		add_pulse(32'd100000, 1'b0, 32'hFFFF_FFFF);  // stuck
		gen_time = 32'd100000;
		wait_until_idle();

		for (int k = 0; k < RANDOM_SETS; k++) begin
			case (k)
				0: load_settings(16'd2100, 16'd80, 16'd5, 16'd2000);
				// zero period and zero windows: only a repeated stamp is overspeed
				1: load_settings(16'd0, 16'd255, 16'd0, 16'd0);
				// upper bits dropped; speed 19 falls back to 100
				2: load_settings(16'hFFFF, 16'hFF13, 16'h01FF, 16'hFFFF);
				3: load_settings(16'd4095, 16'd20, 16'd1, 16'd1);
				4: load_settings(16'd1000, 16'd0, 16'd3, 16'd50);
				default: load_settings(16'($urandom), 16'($urandom),
					16'({8'($urandom), 8'($urandom_range(0, 30))}),
					16'($urandom_range(0, 4000)));
			endcase
			// alternate who idles so gaps land on every stage, with clean stretches
			in_idle_on = (k % 4 == 0) || (k % 4 == 2);
			out_idle_on = (k % 4 == 0) || (k % 4 == 3);
			@(negedge clk);
			queue_random(ITEMS_PER_SET);
			wait_until_idle();
		end

		mismatches += expected_verdicts.size();
		$display("%0d pulse verdicts checked over %0d register settings", verdicts_checked,
			settings_used);
		$display("outcomes: %0d accepted, %0d debounced, %0d stuck, %0d overspeed",
			n_acc, n_deb, n_stuck, n_ovs);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
